// ----- hw/rtl/xcs_pkg.sv -----
// ----------------------------------------------------------------------------
// xcs_pkg
// Types and constants shared by the XMODEM-CRC sender modules.
// ----------------------------------------------------------------------------
package xcs_pkg;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_RX   = 2'd1;
  localparam logic [1:0] CMD_SLOT = 2'd2;
  localparam logic [1:0] CMD_TICK = 2'd3;

  localparam logic [1:0] ST_BUSY      = 2'd0;
  localparam logic [1:0] ST_DONE      = 2'd1;
  localparam logic [1:0] ST_CANCELLED = 2'd2;
  localparam logic [1:0] ST_TIMEOUT   = 2'd3;

  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_EOT = 8'h04;
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [7:0] BYTE_CAN = 8'h18;
  localparam logic [7:0] BYTE_C   = 8'h43;
  localparam logic [7:0] BYTE_PAD = 8'hff;

  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam int          BLOCK_DATA  = 128;
  localparam logic [7:0]  POS_BLK     = 8'd1;
  localparam logic [7:0]  POS_BLK_INV = 8'd2;
  localparam logic [7:0]  POS_DATA    = 8'd3;
  localparam logic [7:0]  POS_CRC_HI  = 8'd131;
  localparam logic [7:0]  POS_LAST    = 8'd132;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  // register word index on the configuration port
  localparam logic REG_ANSWER_TIMEOUT = 1'b0;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       data_last;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [1:0] status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       accept;
    logic       emit;
    logic       clear_xfer;
    logic       load_byte;
    logic       ack_advance;
    logic       frame_restart;
    logic       send_byte;
    logic       send_eot;
    logic       tick;
    logic [1:0] status;
  } xcs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       last;
    logic       is_c;
    logic       is_ack;
    logic       is_can;
    logic       no_data;
    logic       last_block;
    logic       frame_end;
    logic       timer_expired;
  } xcs_stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/xcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// xcs_ctrl
// Handshake sequencer and transfer phase state machine of the sender.
// ----------------------------------------------------------------------------
module xcs_ctrl
  import xcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  xcs_stat_t stat,
  output xcs_cmd_t  cmd
);

  typedef enum logic [1:0] {
    HS_IDLE = 2'b01,
    HS_EXEC = 2'b10
  } hs_state_t;

  typedef enum logic [7:0] {
    PH_LOADING  = 8'b0000_0001,
    PH_WAIT_C   = 8'b0000_0010,
    PH_SENDING  = 8'b0000_0100,
    PH_WAIT_ANS = 8'b0000_1000,
    PH_SEND_EOT = 8'b0001_0000,
    PH_DONE     = 8'b0010_0000,
    PH_CANCEL   = 8'b0100_0000,
    PH_TIMEOUT  = 8'b1000_0000
  } phase_t;

  hs_state_t hs_r, hs_nxt;
  phase_t    phase_r, phase_nxt;

  assign busy = (hs_r == HS_EXEC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r    <= HS_IDLE;
      phase_r <= PH_LOADING;
    end else begin
      hs_r    <= hs_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    hs_nxt    = hs_r;
    phase_nxt = phase_r;
    cmd       = '0;
    case (hs_r)
      HS_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          hs_nxt     = HS_EXEC;
        end
      end
      HS_EXEC: begin
        hs_nxt   = HS_IDLE;
        cmd.emit = 1'b1;
        case (stat.command)
          CMD_LOAD: begin
            if (phase_r inside {PH_LOADING, PH_DONE, PH_CANCEL, PH_TIMEOUT}) begin
              cmd.load_byte  = 1'b1;
              cmd.clear_xfer = (phase_r != PH_LOADING);
              phase_nxt      = stat.last ? PH_WAIT_C : PH_LOADING;
            end
          end
          CMD_RX: begin
            if (phase_r == PH_WAIT_C) begin
              if (stat.is_c) begin
                if (stat.no_data) begin
                  phase_nxt = PH_SEND_EOT;
                end else begin
                  phase_nxt         = PH_SENDING;
                  cmd.frame_restart = 1'b1;
                end
              end
            end else if (phase_r == PH_WAIT_ANS) begin
              if (stat.is_ack) begin
                cmd.ack_advance = 1'b1;
                if (stat.last_block) begin
                  phase_nxt = PH_SEND_EOT;
                end else begin
                  phase_nxt         = PH_SENDING;
                  cmd.frame_restart = 1'b1;
                end
              end else if (stat.is_can) begin
                phase_nxt = PH_CANCEL;
              end else begin
                phase_nxt         = PH_SENDING;
                cmd.frame_restart = 1'b1;
              end
            end
          end
          CMD_SLOT: begin
            if (phase_r == PH_SENDING) begin
              cmd.send_byte = 1'b1;
              if (stat.frame_end) begin
                phase_nxt = PH_WAIT_ANS;
              end
            end else if (phase_r == PH_SEND_EOT) begin
              cmd.send_eot = 1'b1;
              phase_nxt    = PH_DONE;
            end
          end
          default: begin
            if (phase_r == PH_WAIT_ANS) begin
              cmd.tick = 1'b1;
              if (stat.timer_expired) begin
                phase_nxt = PH_TIMEOUT;
              end
            end
          end
        endcase
        case (phase_nxt)
          PH_DONE:    cmd.status = ST_DONE;
          PH_CANCEL:  cmd.status = ST_CANCELLED;
          PH_TIMEOUT: cmd.status = ST_TIMEOUT;
          default:    cmd.status = ST_BUSY;
        endcase
      end
      default: begin
        hs_nxt = HS_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/xcs_datapath.sv -----
// ----------------------------------------------------------------------------
// xcs_datapath
// Payload memory, frame counters, CRC, answer timer and result register.
// ----------------------------------------------------------------------------
module xcs_datapath
  import xcs_pkg::*;
#(
  parameter int MAX_TRANSFER_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_item,
  input  logic [15:0] timeout_ticks,
  input  xcs_cmd_t    cmd,
  output xcs_stat_t   stat,
  output logic        out_valid,
  output out_item_t   out_result
);

  localparam int CW = $clog2(MAX_TRANSFER_BYTES + 1);
  localparam int AW = $clog2(MAX_TRANSFER_BYTES);

  logic [7:0] mem [MAX_TRANSFER_BYTES];

  in_item_t    item_r;
  logic [7:0]  rd_r;
  logic [CW-1:0] loaded_r, loaded_nxt;
  logic [CW-1:0] offset_r, offset_nxt;
  logic [7:0]  block_r, block_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic        out_valid_r;
  out_item_t   out_r, out_nxt;

  logic [CW:0]   rd_idx;
  logic [CW-1:0] load_base;
  logic          wr_en;
  logic [7:0]    data_byte;
  logic [7:0]    frame_byte;
  logic [15:0]   timer_inc;
  logic [CW-1:0] remaining;

  assign rd_idx    = {1'b0, offset_r} + (CW+1)'(pos_r - POS_DATA);
  assign load_base = cmd.clear_xfer ? '0 : loaded_r;
  assign wr_en     = cmd.load_byte && (load_base < CW'(MAX_TRANSFER_BYTES));
  assign data_byte = (rd_idx < {1'b0, loaded_r}) ? rd_r : BYTE_PAD;
  assign timer_inc = (timer_r == 16'hffff) ? timer_r : timer_r + 16'd1;
  assign remaining = loaded_r - offset_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_r   <= mem[rd_idx[AW-1:0]];
      item_r <= in_item;
    end
    if (wr_en) begin
      mem[load_base[AW-1:0]] <= item_r.data_byte;
    end
  end

  always_comb begin
    stat.command       = item_r.command;
    stat.last          = item_r.data_last;
    stat.is_c          = (item_r.data_byte == BYTE_C);
    stat.is_ack        = (item_r.data_byte == BYTE_ACK);
    stat.is_can        = (item_r.data_byte == BYTE_CAN);
    stat.no_data       = (offset_r >= loaded_r);
    stat.last_block    = (remaining <= CW'(BLOCK_DATA));
    stat.frame_end     = (pos_r >= POS_LAST);
    stat.timer_expired = (timer_inc >= timeout_ticks);
  end

  always_comb begin
    loaded_nxt = loaded_r;
    offset_nxt = offset_r;
    block_nxt  = block_r;
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    timer_nxt  = timer_r;
    frame_byte = 8'h00;

    if (cmd.clear_xfer) begin
      loaded_nxt = '0;
      offset_nxt = '0;
      block_nxt  = 8'd1;
      pos_nxt    = '0;
      crc_nxt    = '0;
      timer_nxt  = '0;
    end
    if (wr_en) begin
      loaded_nxt = load_base + CW'(1);
    end
    if (cmd.ack_advance) begin
      block_nxt  = block_r + 8'd1;
      offset_nxt = stat.last_block ? loaded_r : offset_r + CW'(BLOCK_DATA);
    end
    if (cmd.frame_restart) begin
      pos_nxt = '0;
      crc_nxt = '0;
    end
    if (cmd.send_byte) begin
      if (pos_r == 8'd0) begin
        crc_nxt    = '0;
        frame_byte = BYTE_SOH;
      end else if (pos_r == POS_BLK) begin
        frame_byte = block_r;
      end else if (pos_r == POS_BLK_INV) begin
        frame_byte = ~block_r;
      end else if (pos_r < POS_CRC_HI) begin
        frame_byte = data_byte;
        crc_nxt    = crc_byte(crc_r, data_byte);
      end else if (pos_r == POS_CRC_HI) begin
        frame_byte = crc_r[15:8];
      end else begin
        frame_byte = crc_r[7:0];
      end
      pos_nxt = pos_r + 8'd1;
      if (stat.frame_end) begin
        timer_nxt = '0;
      end
    end
    if (cmd.tick) begin
      timer_nxt = timer_inc;
    end

    out_nxt.tx_valid = cmd.send_byte | cmd.send_eot;
    out_nxt.tx_byte  = cmd.send_eot ? BYTE_EOT : frame_byte;
    out_nxt.status   = cmd.status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r    <= '0;
      offset_r    <= '0;
      block_r     <= 8'd1;
      pos_r       <= '0;
      crc_r       <= '0;
      timer_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      loaded_r    <= loaded_nxt;
      offset_r    <= offset_nxt;
      block_r     <= block_nxt;
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      timer_r     <= timer_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

// ----- hw/rtl/xmodem_crc_sender.sv -----
// ----------------------------------------------------------------------------
// xmodem_crc_sender
// Sending side of XMODEM-CRC with a payload buffer and an APB timeout register.
// ----------------------------------------------------------------------------
// The accept edge latches the item and reads the payload memory; the transfer
// state, the CRC and the result register are updated from these registered
// values. busy is high for one cycle after each accept, so a new item is not
// taken until the last one is done. Every accepted item gives exactly one
// result, shown on out_result for one cycle with out_valid high; the receiver
// cannot stall and must take it then. Register 0 at byte address 0 holds
// answer_timeout_ticks.
// ----------------------------------------------------------------------------
module xmodem_crc_sender
  import xcs_pkg::*;
#(
  parameter int MAX_TRANSFER_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_result,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [15:0] timeout_r;
  xcs_cmd_t    cmd;
  xcs_stat_t   stat;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_ANSWER_TIMEOUT) ? {16'h0000, timeout_r}
                                                           : 32'h0000_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr[2] == REG_ANSWER_TIMEOUT)) begin
      timeout_r <= cfg_pwdata[15:0];
    end
  end

  xcs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  xcs_datapath #(
    .MAX_TRANSFER_BYTES (MAX_TRANSFER_BYTES)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_item       (in_item),
    .timeout_ticks (timeout_r),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_result    (out_result)
  );

endmodule
